// File: rtl/idm_pkg.sv
// Package for the IoU detection matcher: command and match codes, field widths,
// near-window limits and the word handed along the divider cell chain.
// Used by every module in the rtl folder except idm_ram.
package idm_pkg;

    localparam int EDGE_W = 13;
    localparam int SPAN_W = 14;
    localparam int AREA_W = 28;
    localparam int UNI_W  = 29;
    localparam int DIV_W  = 28;
    localparam int IOU_W  = 16;
    localparam int CLS_W  = 2;
    localparam int GND_W  = 16;
    localparam int ENTRY_W = 4 * EDGE_W + CLS_W;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_IOU   = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;
    localparam logic [1:0] KIND_LEFT  = 2'd3;

    localparam logic [CLS_W-1:0] CLS_BLUE   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_ORANGE = 2'd2;

    localparam logic signed [GND_W-1:0] NEAR_X_LIM = 16'sd102;
    localparam logic signed [GND_W-1:0] NEAR_Y_IN  = 16'sd103;
    localparam logic signed [GND_W-1:0] NEAR_Y_OUT = 16'sd255;

    localparam logic [15:0] THRESH_RESET = 16'd13107;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             zero;
        logic             sat;
        logic [CLS_W-1:0] cls;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [IOU_W-1:0] quo;
    } div_word_t;

endpackage

// File: rtl/idm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependency.
module idm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/idm_front.sv
// IoU front end: overlap spans, areas and union for one table entry, three stages.
// Depends on idm_pkg; feeds the first divider cell.
module idm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_v,
    input  logic                             in_last,
    input  logic [idm_pkg::ENTRY_W-1:0]      entry,
    input  logic signed [idm_pkg::EDGE_W-1:0] q_l,
    input  logic signed [idm_pkg::EDGE_W-1:0] q_r,
    input  logic signed [idm_pkg::EDGE_W-1:0] q_t,
    input  logic signed [idm_pkg::EDGE_W-1:0] q_b,
    input  logic signed [idm_pkg::AREA_W-1:0] q_area,
    output idm_pkg::div_word_t               word
);

    logic signed [idm_pkg::EDGE_W-1:0] e_l, e_r, e_t, e_b;
    logic [idm_pkg::CLS_W-1:0]          e_cls;
    logic signed [idm_pkg::EDGE_W-1:0] xl, xr, yt, yb;

    logic [1:0] v_reg, last_reg;
    logic signed [idm_pkg::SPAN_W-1:0] dx_reg, dy_reg, ew_reg, eh_reg;
    logic [idm_pkg::CLS_W-1:0] cls1_reg, cls2_reg;
    logic neg_reg;
    logic signed [idm_pkg::AREA_W-1:0] inter_reg, a2_reg;
    logic signed [idm_pkg::UNI_W-1:0]  uni;
    idm_pkg::div_word_t word_reg;

    assign {e_cls, e_b, e_t, e_r, e_l} = entry;
    assign xl = (q_l > e_l) ? q_l : e_l;
    assign yt = (q_t > e_t) ? q_t : e_t;
    assign xr = (q_r < e_r) ? q_r : e_r;
    assign yb = (q_b < e_b) ? q_b : e_b;

    assign uni = idm_pkg::UNI_W'(q_area) + idm_pkg::UNI_W'(a2_reg)
               - idm_pkg::UNI_W'(inter_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            last_reg <= '0;
        end
        else
        begin
            v_reg    <= {v_reg[0], in_v};
            last_reg <= {last_reg[0], in_last};
        end
    end

    always_ff @(posedge clk)
    begin
        // spans and entry extent
        dx_reg   <= idm_pkg::SPAN_W'(xr) - idm_pkg::SPAN_W'(xl);
        dy_reg   <= idm_pkg::SPAN_W'(yb) - idm_pkg::SPAN_W'(yt);
        ew_reg   <= idm_pkg::SPAN_W'(e_r) - idm_pkg::SPAN_W'(e_l);
        eh_reg   <= idm_pkg::SPAN_W'(e_b) - idm_pkg::SPAN_W'(e_t);
        cls1_reg <= e_cls;
        // products
        neg_reg   <= dx_reg[idm_pkg::SPAN_W-1] | dy_reg[idm_pkg::SPAN_W-1];
        inter_reg <= dx_reg * dy_reg;
        a2_reg    <= ew_reg * eh_reg;
        cls2_reg  <= cls1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg.valid <= v_reg[1];
            word_reg.last  <= last_reg[1];
            word_reg.zero  <= neg_reg || (inter_reg <= 0) || (uni <= 0);
            word_reg.sat   <= idm_pkg::UNI_W'(inter_reg) >= uni;
            word_reg.cls   <= cls2_reg;
            word_reg.rem   <= idm_pkg::DIV_W'(inter_reg);
            word_reg.dvs   <= idm_pkg::DIV_W'(uni);
            word_reg.quo   <= '0;
        end
    end

    assign word = word_reg;

endmodule

// File: rtl/idm_div_cell.sv
// One restoring-division cell: one quotient bit per cell, registered output.
// Depends on idm_pkg.
module idm_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  idm_pkg::div_word_t din,
    output idm_pkg::div_word_t dout
);

    logic [idm_pkg::DIV_W:0] rem2;
    logic                    take;
    idm_pkg::div_word_t      dout_reg;

    assign rem2 = {din.rem, 1'b0};
    assign take = rem2 >= {1'b0, din.dvs};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg.valid <= din.valid;
            dout_reg.last  <= din.last;
            dout_reg.zero  <= din.zero;
            dout_reg.sat   <= din.sat;
            dout_reg.cls   <= din.cls;
            dout_reg.dvs   <= din.dvs;
            dout_reg.rem   <= take ? idm_pkg::DIV_W'(rem2 - {1'b0, din.dvs})
                                   : idm_pkg::DIV_W'(rem2);
            dout_reg.quo   <= {din.quo[idm_pkg::IOU_W-2:0], take};
        end
    end

    assign dout = dout_reg;

endmodule

// File: rtl/iou_detection_matcher.sv
// IoU detection matcher: detection table in RAM, IoU front end, chain of 16 divider cells.
// Clear and load complete in the idle state. A query with N > 0 stored entries passes through
// N table reads, RAM, three front-end and sixteen cell stages and the decision before out_valid;
// an empty table goes straight to the decision. The next word is taken once control is idle.
// One query at a time; a stalled output holds the query in its last state until free.
// Reset (async, active low) empties the table, sets the threshold to 13107, idles control.
module iou_detection_matcher #(
    parameter int MAX_DETECTIONS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic signed [idm_pkg::EDGE_W-1:0] rect_left,
    input  logic signed [idm_pkg::EDGE_W-1:0] rect_right,
    input  logic signed [idm_pkg::EDGE_W-1:0] rect_top,
    input  logic signed [idm_pkg::EDGE_W-1:0] rect_bottom,
    input  logic [idm_pkg::CLS_W-1:0]         colour_class,
    input  logic signed [idm_pkg::GND_W-1:0]  ground_x,
    input  logic signed [idm_pkg::GND_W-1:0]  ground_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        match_kind,
    output logic [idm_pkg::CLS_W-1:0]         class_out,
    output logic [idm_pkg::IOU_W-1:0]         best_iou,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [15:0]                       cfg_data
);

    localparam int AW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CW = $clog2(MAX_DETECTIONS + 1);
    localparam int NCELL = idm_pkg::IOU_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [15:0]   thresh_reg;

    logic signed [idm_pkg::EDGE_W-1:0] ql_reg, qr_reg, qt_reg, qb_reg;
    logic signed [idm_pkg::GND_W-1:0]  gx_reg, gy_reg;
    logic signed [idm_pkg::AREA_W-1:0] qarea_reg;
    logic signed [idm_pkg::SPAN_W-1:0] qw, qh;

    logic [idm_pkg::IOU_W-1:0] best_reg, best_next;
    logic [idm_pkg::CLS_W-1:0] bcls_reg, bcls_next;

    logic out_valid_reg;
    logic [1:0] kind_reg;
    logic [idm_pkg::CLS_W-1:0] cls_out_reg;
    logic [idm_pkg::IOU_W-1:0] iou_out_reg;

    logic accept, issue, issue_last, rd_v_reg, rd_last_reg;
    logic we;
    logic [idm_pkg::ENTRY_W-1:0] rdata;
    logic [idm_pkg::IOU_W-1:0] v;
    logic out_free;
    logic [1:0] kind_c;
    logic [idm_pkg::CLS_W-1:0] cls_c;
    logic near_x;

    idm_pkg::div_word_t chain [0:NCELL];

    assign accept    = in_valid & ~in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = ~out_valid_reg | ~out_stall;

    // table write on load while room is left
    assign we = accept && (cmd == idm_pkg::CMD_LOAD) && (count_reg < CW'(MAX_DETECTIONS));

    assign issue      = (state_reg == ST_RUN);
    assign issue_last = (idx_reg == count_reg - CW'(1));

    idm_ram #(
        .WIDTH (idm_pkg::ENTRY_W),
        .DEPTH (MAX_DETECTIONS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({colour_class, rect_bottom, rect_top, rect_right, rect_left}),
        .raddr (idx_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg    <= issue;
            rd_last_reg <= issue & issue_last;
        end
    end

    idm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_v    (rd_v_reg),
        .in_last (rd_last_reg),
        .entry   (rdata),
        .q_l     (ql_reg),
        .q_r     (qr_reg),
        .q_t     (qt_reg),
        .q_b     (qb_reg),
        .q_area  (qarea_reg),
        .word    (chain[0])
    );

    // one quotient bit per cell, sixteen in a row
    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        idm_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // IoU of the word leaving the chain
    assign v = chain[NCELL].zero ? '0
             : chain[NCELL].sat  ? '1
             : chain[NCELL].quo;

    // query area, held steady for the whole scan
    assign qw = idm_pkg::SPAN_W'(qr_reg) - idm_pkg::SPAN_W'(ql_reg);
    assign qh = idm_pkg::SPAN_W'(qb_reg) - idm_pkg::SPAN_W'(qt_reg);

    always_ff @(posedge clk)
    begin
        qarea_reg <= qw * qh;
        if (accept && cmd == idm_pkg::CMD_QUERY)
        begin
            ql_reg <= rect_left;
            qr_reg <= rect_right;
            qt_reg <= rect_top;
            qb_reg <= rect_bottom;
            gx_reg <= ground_x;
            gy_reg <= ground_y;
        end
    end

    // near-cone windows and final decision
    assign near_x = (gx_reg >= -idm_pkg::NEAR_X_LIM) && (gx_reg <= idm_pkg::NEAR_X_LIM);

    always_comb
    begin
        kind_c = idm_pkg::KIND_NONE;
        cls_c  = '0;
        if ({16'd0, best_reg} > {16'd0, thresh_reg})
        begin
            kind_c = idm_pkg::KIND_IOU;
            cls_c  = bcls_reg;
        end
        else if (near_x)
        begin
            if (gy_reg >= -idm_pkg::NEAR_Y_OUT && gy_reg <= -idm_pkg::NEAR_Y_IN)
            begin
                kind_c = idm_pkg::KIND_RIGHT;
                cls_c  = idm_pkg::CLS_BLUE;
            end
            else if (gy_reg >= idm_pkg::NEAR_Y_IN && gy_reg <= idm_pkg::NEAR_Y_OUT)
            begin
                kind_c = idm_pkg::KIND_LEFT;
                cls_c  = idm_pkg::CLS_ORANGE;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        bcls_next  = bcls_reg;
        // keep the first strict maximum; words may leave the chain while the scan still runs
        if ((state_reg == ST_RUN || state_reg == ST_WAIT) && chain[NCELL].valid
            && (v > best_reg))
        begin
            best_next = v;
            bcls_next = chain[NCELL].cls;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        idm_pkg::CMD_CLEAR: count_next = '0;
                        idm_pkg::CMD_LOAD:
                        begin
                            if (we)
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        idm_pkg::CMD_QUERY:
                        begin
                            best_next  = '0;
                            bcls_next  = '0;
                            idx_next   = '0;
                            state_next = (count_reg == '0) ? ST_DONE : ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN:
            begin
                // advance through the table, one read per cycle
                idx_next = idx_reg + CW'(1);
                if (issue_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (chain[NCELL].valid && chain[NCELL].last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            best_reg      <= '0;
            bcls_reg      <= '0;
            thresh_reg    <= idm_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            best_reg  <= best_next;
            bcls_reg  <= bcls_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            kind_reg    <= kind_c;
            cls_out_reg <= cls_c;
            iou_out_reg <= best_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign match_kind = kind_reg;
    assign class_out  = cls_out_reg;
    assign best_iou   = iou_out_reg;

endmodule

// File: tb/testbench.sv
// Self-checking bench for iou_detection_matcher: directed table, then random scenes.
// Holds its own IoU predictor and threshold copy; depends on rtl/idm_pkg.sv and the top RTL.
module testbench;

    localparam logic [1:0] CMD_SPARE   = 2'd3;   // unused command code, must be ignored
    localparam int         TABLE_DEPTH = 64;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         QUIET_GAP   = 120;    // longest query (64 entries) plus margin
    localparam int         WORD_TARGET = 1800;

    typedef struct packed {
        logic [1:0]                kind;
        logic [idm_pkg::CLS_W-1:0] cls;
        logic [idm_pkg::IOU_W-1:0] iou;
    } match_t;

    typedef struct {
        logic [1:0] op;
        int         l, r, t, b;
        int         cls;
        int         gx, gy;
        bit         typed;
        match_t     want;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [1:0]                        cmd;
    logic signed [idm_pkg::EDGE_W-1:0] rect_left, rect_right, rect_top, rect_bottom;
    logic [idm_pkg::CLS_W-1:0]         colour_class;
    logic signed [idm_pkg::GND_W-1:0]  ground_x, ground_y;
    logic                              out_valid;
    logic                              out_stall;
    logic [1:0]                        match_kind;
    logic [idm_pkg::CLS_W-1:0]         class_out;
    logic [idm_pkg::IOU_W-1:0]         best_iou;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [15:0]                       cfg_data;

    // Typed expectation for the word now on the input, if any
    bit     typed_on;
    match_t typed_want;

    // Predictor state
    int          det_l [TABLE_DEPTH];
    int          det_r [TABLE_DEPTH];
    int          det_t [TABLE_DEPTH];
    int          det_b [TABLE_DEPTH];
    int          det_c [TABLE_DEPTH];
    int          det_count = 0;
    logic [15:0] iou_floor = idm_pkg::THRESH_RESET;

    match_t pending_matches[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     words_sent;

    iou_detection_matcher #(.MAX_DETECTIONS(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .rect_left(rect_left), .rect_right(rect_right),
        .rect_top(rect_top), .rect_bottom(rect_bottom), .colour_class(colour_class),
        .ground_x(ground_x), .ground_y(ground_y),
        .out_valid(out_valid), .out_stall(out_stall),
        .match_kind(match_kind), .class_out(class_out), .best_iou(best_iou),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Exact IoU in Q0.16, floored and saturated
    function automatic logic [15:0] overlap_ratio(int ql, int qr, int qt, int qb,
                                                  int el, int er, int et, int eb);
        int     xl, xr, yt, yb;
        longint inter, a1, a2, uni, q;
        xl = (ql > el) ? ql : el;
        xr = (qr < er) ? qr : er;
        yt = (qt > et) ? qt : et;
        yb = (qb < eb) ? qb : eb;
        if (xr < xl || yb < yt)
            return 16'd0;
        inter = longint'(xr - xl) * longint'(yb - yt);
        a1    = longint'(qr - ql) * longint'(qb - qt);
        a2    = longint'(er - el) * longint'(eb - et);
        uni   = a1 + a2 - inter;
        if (uni <= 0 || inter <= 0)
            return 16'd0;
        q = (inter * 65536) / uni;
        if (q > 65535)
            q = 65535;
        return q[15:0];
    endfunction

    // Best first strict maximum over the table, then the near-cone windows
    function automatic match_t predict_match(int ql, int qr, int qt, int qb, int gx, int gy);
        match_t      m;
        logic [15:0] v;
        logic [15:0] top;
        int          top_cls;
        top     = 16'd0;
        top_cls = 0;
        for (int i = 0; i < det_count; i++)
        begin
            v = overlap_ratio(ql, qr, qt, qb, det_l[i], det_r[i], det_t[i], det_b[i]);
            if (v > top)
            begin
                top     = v;
                top_cls = det_c[i];
            end
        end
        m.iou  = top;
        m.kind = idm_pkg::KIND_NONE;
        m.cls  = '0;
        if (top > iou_floor)
        begin
            m.kind = idm_pkg::KIND_IOU;
            m.cls  = top_cls[idm_pkg::CLS_W-1:0];
        end
        else if (gx >= -idm_pkg::NEAR_X_LIM && gx <= idm_pkg::NEAR_X_LIM)
        begin
            if (gy >= -idm_pkg::NEAR_Y_OUT && gy <= -idm_pkg::NEAR_Y_IN)
            begin
                m.kind = idm_pkg::KIND_RIGHT;
                m.cls  = idm_pkg::CLS_BLUE;
            end
            else if (gy >= idm_pkg::NEAR_Y_IN && gy <= idm_pkg::NEAR_Y_OUT)
            begin
                m.kind = idm_pkg::KIND_LEFT;
                m.cls  = idm_pkg::CLS_ORANGE;
            end
        end
        return m;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // Track accepted words, configuration writes and returned results on the rising edge
    always @(posedge clk)
    begin
        match_t m;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                iou_floor = cfg_data;
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    idm_pkg::CMD_CLEAR: det_count = 0;
                    idm_pkg::CMD_LOAD:
                        if (det_count < TABLE_DEPTH)
                        begin
                            det_l[det_count] = rect_left;
                            det_r[det_count] = rect_right;
                            det_t[det_count] = rect_top;
                            det_b[det_count] = rect_bottom;
                            det_c[det_count] = colour_class;
                            det_count++;
                        end
                    idm_pkg::CMD_QUERY:
                    begin
                        m = predict_match(rect_left, rect_right, rect_top, rect_bottom,
                                          ground_x, ground_y);
                        // A typed row must agree with the predictor too
                        if (typed_on && m != typed_want)
                            report_mismatch("predictor vs typed row", int'(m),
                                            int'(typed_want));
                        pending_matches = {pending_matches, (typed_on ? typed_want : m)};
                    end
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                    report_mismatch("unexpected result, kind", match_kind, -1);
                else
                begin
                    m = pending_matches.pop_front();
                    if (match_kind !== m.kind)
                        report_mismatch("match_kind", match_kind, m.kind);
                    if (class_out !== m.cls)
                        report_mismatch("class_out", class_out, m.cls);
                    if (best_iou !== m.iou)
                        report_mismatch("best_iou", best_iou, m.iou);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stall: mostly short runs, the odd long one, and quiet stretches
    always @(negedge clk)
    begin
        int run_left;
        int pick;
        if (run_left == 0)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 11)
            begin
                out_stall <= 1'b0;
                run_left = $urandom_range(1, 12);
            end
            else if (pick < 13)
            begin
                out_stall <= 1'b0;
                run_left = $urandom_range(80, 300);
            end
            else if (pick < 19)
            begin
                out_stall <= 1'b1;
                run_left = $urandom_range(1, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                run_left = $urandom_range(15, 50);
            end
        end
        else
            run_left--;
    end

    function automatic int sender_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11) return 0;
        if (pick < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_edge(int v);
        if (v < -4096) return -4096;
        if (v > 4095)  return 4095;
        return v;
    endfunction

    // Drive one word from the falling edge and hold it until accepted
    task automatic send_word(stim_row_t w);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd          = w.op;
        rect_left    = w.l[idm_pkg::EDGE_W-1:0];
        rect_right   = w.r[idm_pkg::EDGE_W-1:0];
        rect_top     = w.t[idm_pkg::EDGE_W-1:0];
        rect_bottom  = w.b[idm_pkg::EDGE_W-1:0];
        colour_class = w.cls[idm_pkg::CLS_W-1:0];
        ground_x     = w.gx[idm_pkg::GND_W-1:0];
        ground_y     = w.gy[idm_pkg::GND_W-1:0];
        typed_on     = w.typed;
        typed_want   = w.want;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Drain every result, let a trailing load or clear settle, then write the threshold
    task automatic write_threshold(logic [15:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        typed_on = 1'b0;
        wait (pending_matches.size() == 0);
        repeat (QUIET_GAP) @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic stim_row_t make_row(logic [1:0] op, int l, int r, int t, int b,
                                          int cls, int gx, int gy, bit typed = 1'b0,
                                          logic [1:0] kind = idm_pkg::KIND_NONE,
                                          int wcls = 0, int wiou = 0);
        stim_row_t s;
        s.op = op; s.l = l; s.r = r; s.t = t; s.b = b; s.cls = cls;
        s.gx = gx; s.gy = gy; s.typed = typed;
        s.want.kind = kind;
        s.want.cls  = wcls[idm_pkg::CLS_W-1:0];
        s.want.iou  = wiou[idm_pkg::IOU_W-1:0];
        return s;
    endfunction

    function automatic stim_row_t noise_word();
        return make_row(2'($urandom_range(0, 3)), $urandom_range(0, 8191) - 4096,
                        $urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                        $urandom_range(0, 8191) - 4096, $urandom_range(0, 3),
                        $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
    endfunction

    // Ground centre: hover around the near windows, sometimes anywhere
    task automatic pick_ground(output int gx, output int gy);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            gx = $urandom_range(0, 240) - 120;
            gy = $urandom_range(0, 600) - 300;
        end
        else
        begin
            gx = $urandom_range(0, 65535) - 32768;
            gy = $urandom_range(0, 65535) - 32768;
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        stim_row_t w;
        int        sl[$], sr[$], st[$], sb[$];
        int        n_load, n_query, k, cx, cy, wd, ht, gx, gy, j;
        logic [15:0] phase_floor[$];

        rst_n = 1'b0; in_valid = 1'b0; cfg_valid = 1'b0;
        cfg_data = '0; cmd = idm_pkg::CMD_CLEAR; rect_left = '0; rect_right = '0;
        rect_top = '0; rect_bottom = '0; colour_class = '0; ground_x = '0;
        ground_y = '0; typed_on = 1'b0; typed_want = '0;
        words_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: empty table and window edges, ties, touching, inverted, extremes
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 0, 0,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 0, -103,
                               1, idm_pkg::KIND_RIGHT, 1, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 0, 103,
                               1, idm_pkg::KIND_LEFT, 2, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 102, -255,
                               1, idm_pkg::KIND_RIGHT, 1, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, -102, 255,
                               1, idm_pkg::KIND_LEFT, 2, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, -103, -200,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 0, 256,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 10, 0, 10, 0, 0, -102,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_LOAD, 0, 100, 0, 100, 2, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 100, 0, 100, 0, 0, 0,
                               1, idm_pkg::KIND_IOU, 2, 65535)};
        rows = {rows, make_row(idm_pkg::CMD_LOAD, 0, 100, 0, 100, 1, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 100, 0, 100, 0, 0, 0,
                               1, idm_pkg::KIND_IOU, 2, 65535)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 200, 300, 0, 100, 0, 0, 0,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 100, 200, 0, 100, 0, 0, 0,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 50, 0, 100, 0, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_LOAD, 100, 0, 100, 0, 3, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 100, 0, 100, 0, 0, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_LOAD, -4096, 4095, -4096, 4095, 3, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, -4096, 4095, -4096, 4095, 3,
                               32767, -32768)};
        rows = {rows, make_row(CMD_SPARE, -1, -1, -1, -1, 3, -1, -1)};
        rows = {rows, make_row(idm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, 0, 100, 0, 100, 0, 0, 0,
                               1, idm_pkg::KIND_NONE, 0, 0)};
        rows = {rows, make_row(idm_pkg::CMD_QUERY, -4096, -4096, -4096, -4096, 0,
                               -32768, 32767, 1, idm_pkg::KIND_NONE, 0, 0)};
        foreach (rows[i])
            send_word(rows[i]);

        // Random phases, each under its own threshold; extremes first
        phase_floor = '{16'd0, 16'd65535, 16'd32768, idm_pkg::THRESH_RESET,
                        16'd0, 16'd0, 16'd0};
        for (int p = 4; p < phase_floor.size(); p++)
            phase_floor[p] = 16'($urandom_range(0, 65535));
        foreach (phase_floor[p])
        begin
            write_threshold(phase_floor[p]);
            while (words_sent < 25 + (WORD_TARGET * (p + 1)) / phase_floor.size())
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(noise_word());
                    continue;
                end
                // Scene: usually clear, load some rectangles, query near them
                if ($urandom_range(0, 4) != 0)
                    send_word(make_row(idm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
                sl.delete(); sr.delete(); st.delete(); sb.delete();
                n_load = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(0, 8);
                for (k = 0; k < n_load; k++)
                begin
                    cx = $urandom_range(0, 8191) - 4096;
                    cy = $urandom_range(0, 8191) - 4096;
                    wd = $urandom_range(1, 400);
                    ht = $urandom_range(1, 400);
                    w  = make_row(idm_pkg::CMD_LOAD, clamp_edge(cx - wd / 2),
                                  clamp_edge(cx + wd / 2),
                                  clamp_edge(cy - ht / 2), clamp_edge(cy + ht / 2),
                                  $urandom_range(0, 3), 0, 0);
                    if ($urandom_range(0, 15) == 0)
                    begin
                        j = w.l; w.l = w.r; w.r = j;
                    end
                    sl = {sl, w.l}; sr = {sr, w.r}; st = {st, w.t}; sb = {sb, w.b};
                    send_word(w);
                end
                n_query = $urandom_range(1, 6);
                for (k = 0; k < n_query; k++)
                begin
                    pick_ground(gx, gy);
                    if (sl.size() > 0 && $urandom_range(0, 4) != 0)
                    begin
                        j = $urandom_range(0, sl.size() - 1);
                        wd = $urandom_range(0, 60);
                        w = make_row(idm_pkg::CMD_QUERY,
                                     clamp_edge(sl[j] + $urandom_range(0, 2 * wd) - wd),
                                     clamp_edge(sr[j] + $urandom_range(0, 2 * wd) - wd),
                                     clamp_edge(st[j] + $urandom_range(0, 2 * wd) - wd),
                                     clamp_edge(sb[j] + $urandom_range(0, 2 * wd) - wd),
                                     $urandom_range(0, 3), gx, gy);
                    end
                    else
                    begin
                        w = noise_word();
                        w.op = idm_pkg::CMD_QUERY; w.gx = gx; w.gy = gy;
                    end
                    send_word(w);
                end
            end
        end

        // Let everything drain, then allow for stray late results
        @(negedge clk);
        in_valid = 1'b0;
        typed_on = 1'b0;
        wait (pending_matches.size() == 0);
        repeat (QUIET_GAP) @(posedge clk);
        if (pending_matches.size() != 0)
            report_mismatch("results left over", pending_matches.size(), 0);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/idm_pkg.sv
rtl/idm_ram.sv
rtl/idm_front.sv
rtl/idm_div_cell.sv
rtl/iou_detection_matcher.sv
tb/testbench.sv
